// ===== hdl/qbsa_pkg.sv =====
// ----------------------------------------------------------------------------
// qbsa_pkg
// Shared widths, codes and types of the quadratic band spectrum averager.
// ----------------------------------------------------------------------------
package qbsa_pkg;

   localparam int MAX_BANDS   = 64;
   localparam int MAX_BINS    = 4096;

   localparam int BIN_W       = 16;
   localparam int INDEX_W     = 6;
   localparam int LEVEL_W     = 16;
   localparam int BANDS_W     = 7;
   localparam int SIZE_W      = 13;
   localparam int POS_W       = 13;
   localparam int SUM_W       = 29;
   localparam int SQ_W        = 13;
   localparam int DIV_NUM_W   = 29;
   localparam int DIV_DEN_W   = 14;
   localparam int DIV_CNT_W   = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic signed [SUM_W-1:0] LEVEL_OFFSET = SUM_W'(12288);

   localparam logic [BANDS_W-1:0] BANDS_RESET = BANDS_W'(32);
   localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(512);

   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_COUNT    = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPECTRUM_SIZE = CSR_INDEX_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EDGE_SQ,
      ST_EDGE_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_PRE,
      PH_POST,
      PH_FLUSH,
      PH_REST
   } phase_type;

   typedef enum logic {
      DIV_EDGE,
      DIV_MEAN
   } div_kind_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_rsp_type;

endpackage

// ===== hdl/qbsa_if.sv =====
// ----------------------------------------------------------------------------
// qbsa_req_if / qbsa_rsp_if
// Valid/ready channels carrying spectrum bins in and band results out.
// ----------------------------------------------------------------------------
interface qbsa_req_if;
   import qbsa_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [BIN_W-1:0] bin_value;
   logic                    last_bin;

   modport source (output valid, bin_value, last_bin, input ready);
   modport sink   (input valid, bin_value, last_bin, output ready);
endinterface

interface qbsa_rsp_if;
   import qbsa_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [INDEX_W-1:0]        band_index;
   logic signed [LEVEL_W-1:0] band_level;
   logic                      empty_band;
   logic                      last_band;

   modport source (output valid, band_index, band_level, empty_band, last_band, input ready);
   modport sink   (input valid, band_index, band_level, empty_band, last_band, output ready);
endinterface

// ===== hdl/quadratic_band_spectrum_averager_core.sv =====
// ----------------------------------------------------------------------------
// quadratic_band_spectrum_averager_core
// Groups log10 spectrum bins into quadratically widening bands and reports
// the mean mapped level of each band.
// ----------------------------------------------------------------------------
// A bin that closes no band passes through the check state twice before the
// block is ready again. Each band reported runs the bit-serial divider once
// for its mean, unless the band is empty, and once for the next band edge,
// unless it is the last band, plus setup. After reset, after any register
// write and after a bin marked last, the block computes the edge of band 0
// before it takes the next word. Zero width leading bands come out at the
// start of the next word. Results leave through one output register; the block waits while it is full.
module quadratic_band_spectrum_averager_core (
   input  logic                              clock,
   input  logic                              reset,
   qbsa_req_if.sink                          req_if,
   qbsa_rsp_if.source                        rsp_if,
   input  logic                              csr_write_enable,
   input  logic [qbsa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [qbsa_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import qbsa_pkg::*;

   state_type               state_ff, state_in;
   phase_type               phase_ff, phase_in;
   div_kind_type            kind_ff, kind_in;
   logic [BANDS_W-1:0]      band_count_ff, band_count_in;
   logic [SIZE_W-1:0]       spectrum_size_ff, spectrum_size_in;
   logic [POS_W-1:0]        bin_pos_ff, bin_pos_in;
   logic [BANDS_W-1:0]      band_pos_ff, band_pos_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [POS_W-1:0]        count_ff, count_in;
   logic [POS_W-1:0]        end_ff, end_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic signed [BIN_W-1:0] value_ff, value_in;
   logic                    last_ff, last_in;
   logic                    empty_ff, empty_in;
   logic [SQ_W-1:0]         sq_ff, sq_in;
   logic [SQ_W-1:0]         bsq_ff, bsq_in;
   logic [INDEX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic signed [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [BANDS_W-1:0]      eff_bands;
   logic [SIZE_W-1:0]       eff_size;
   logic [BANDS_W-1:0]      band_next;
   logic                    emit_cond;
   logic                    out_free;
   logic [SUM_W-1:0]        sum_mag;
   logic [DIV_DEN_W-1:0]    den3;
   logic [DIV_NUM_W-1:0]    quot;
   logic signed [LEVEL_W-1:0] level_sat;

   div_req_type             div_req;
   div_rsp_type             div_rsp;

   qbsa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      if (band_count_ff == '0) begin
         eff_bands = BANDS_W'(1);
      end else if (band_count_ff > BANDS_W'(MAX_BANDS)) begin
         eff_bands = BANDS_W'(MAX_BANDS);
      end else begin
         eff_bands = band_count_ff;
      end
      if (spectrum_size_ff == '0) begin
         eff_size = SIZE_W'(1);
      end else if (spectrum_size_ff > SIZE_W'(MAX_BINS)) begin
         eff_size = SIZE_W'(MAX_BINS);
      end else begin
         eff_size = spectrum_size_ff;
      end
   end

   always_comb begin
      band_next = band_pos_ff + BANDS_W'(1);
      emit_cond = (band_pos_ff < eff_bands) &&
                  ((end_ff <= bin_pos_ff) || (phase_ff == PH_FLUSH));
      out_free  = !rsp_valid_ff || rsp_if.ready;
      sum_mag   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      den3      = DIV_DEN_W'({count_ff, 1'b0}) + DIV_DEN_W'(count_ff);
      quot      = div_rsp.quot;
      if (sum_ff[SUM_W-1]) begin
         level_sat = (quot >= DIV_NUM_W'(32768)) ? LEVEL_W'(16'h8000)
                                                 : LEVEL_W'(-quot[LEVEL_W-1:0]);
      end else begin
         level_sat = (quot >= DIV_NUM_W'(32767)) ? LEVEL_W'(16'h7FFF)
                                                 : LEVEL_W'(quot[LEVEL_W-1:0]);
      end
   end

   always_comb begin
      state_in         = state_ff;
      phase_in         = phase_ff;
      kind_in          = kind_ff;
      band_count_in    = band_count_ff;
      spectrum_size_in = spectrum_size_ff;
      bin_pos_in       = bin_pos_ff;
      band_pos_in      = band_pos_ff;
      sum_in           = sum_ff;
      count_in         = count_ff;
      end_in           = end_ff;
      value_in         = value_ff;
      last_in          = last_ff;
      empty_in         = empty_ff;
      sq_in            = sq_ff;
      bsq_in           = bsq_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_if.ready;
      rsp_index_in     = rsp_index_ff;
      rsp_level_in     = rsp_level_ff;
      rsp_empty_in     = rsp_empty_ff;
      rsp_last_in      = rsp_last_ff;
      div_req          = '{start: 1'b0, num: '0, den: '0};
      req_if.ready     = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               value_in = req_if.bin_value;
               last_in  = req_if.last_bin;
               phase_in = PH_PRE;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (emit_cond) begin
               if (count_ff == '0) begin
                  empty_in = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  empty_in      = 1'b0;
                  div_req.start = 1'b1;
                  div_req.num   = sum_mag + DIV_NUM_W'(den3 >> 1);
                  div_req.den   = den3;
                  kind_in       = DIV_MEAN;
                  state_in      = ST_DIV;
               end
            end else begin
               unique case (phase_ff)
                  PH_PRE: begin
                     if (bin_pos_ff < eff_size) begin
                        sum_in     = sum_ff + SUM_W'(value_ff) + LEVEL_OFFSET;
                        count_in   = count_ff + POS_W'(1);
                        bin_pos_in = bin_pos_ff + POS_W'(1);
                     end
                     phase_in = PH_POST;
                  end
                  PH_POST: begin
                     if (last_ff) begin
                        phase_in = PH_FLUSH;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
                  PH_FLUSH: begin
                     bin_pos_in  = '0;
                     band_pos_in = '0;
                     sum_in      = '0;
                     count_in    = '0;
                     phase_in    = PH_REST;
                     state_in    = ST_EDGE_SQ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_EDGE_SQ: begin
            sq_in    = SQ_W'(band_next) * SQ_W'(band_next);
            bsq_in   = SQ_W'(eff_bands) * SQ_W'(eff_bands);
            state_in = ST_EDGE_MUL;
         end
         ST_EDGE_MUL: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(sq_ff) * DIV_NUM_W'(eff_size);
            div_req.den   = DIV_DEN_W'(bsq_ff);
            kind_in       = DIV_EDGE;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (kind_ff == DIV_EDGE) begin
                  end_in   = quot[POS_W-1:0];
                  state_in = (phase_ff == PH_REST) ? ST_IDLE : ST_CHECK;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = band_pos_ff[INDEX_W-1:0];
               rsp_level_in = empty_ff ? '0 : level_sat;
               rsp_empty_in = empty_ff;
               rsp_last_in  = (band_next == eff_bands);
               band_pos_in  = band_next;
               sum_in       = '0;
               count_in     = '0;
               state_in     = (band_next < eff_bands) ? ST_EDGE_SQ : ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write_enable &&
          ((csr_index == CSR_BAND_COUNT) || (csr_index == CSR_SPECTRUM_SIZE))) begin
         if (csr_index == CSR_BAND_COUNT) begin
            band_count_in = csr_write_data[BANDS_W-1:0];
         end else begin
            spectrum_size_in = csr_write_data[SIZE_W-1:0];
         end
         bin_pos_in    = '0;
         band_pos_in   = '0;
         sum_in        = '0;
         count_in      = '0;
         phase_in      = PH_REST;
         state_in      = ST_EDGE_SQ;
         div_req.start = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_EDGE_SQ;
         phase_ff         <= PH_REST;
         kind_ff          <= DIV_EDGE;
         band_count_ff    <= BANDS_RESET;
         spectrum_size_ff <= SIZE_RESET;
         bin_pos_ff       <= '0;
         band_pos_ff      <= '0;
         sum_ff           <= '0;
         count_ff         <= '0;
         end_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         phase_ff         <= phase_in;
         kind_ff          <= kind_in;
         band_count_ff    <= band_count_in;
         spectrum_size_ff <= spectrum_size_in;
         bin_pos_ff       <= bin_pos_in;
         band_pos_ff      <= band_pos_in;
         sum_ff           <= sum_in;
         count_ff         <= count_in;
         end_ff           <= end_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      last_ff      <= last_in;
      empty_ff     <= empty_in;
      sq_ff        <= sq_in;
      bsq_ff       <= bsq_in;
      rsp_index_ff <= rsp_index_in;
      rsp_level_ff <= rsp_level_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.band_index = rsp_index_ff;
   assign rsp_if.band_level = rsp_level_ff;
   assign rsp_if.empty_band = rsp_empty_ff;
   assign rsp_if.last_band  = rsp_last_ff;

endmodule

// ===== hdl/qbsa_div.sv =====
// ----------------------------------------------------------------------------
// qbsa_div
// Restoring divider, one quotient bit per cycle, shared by band edge and
// band mean computation.
// ----------------------------------------------------------------------------
module qbsa_div (
   input  logic                  clock,
   input  logic                  reset,
   input  qbsa_pkg::div_req_type div_req,
   output qbsa_pkg::div_rsp_type div_rsp
);
   import qbsa_pkg::*;

   logic [DIV_NUM_W-1:0] q_ff, q_in;
   logic [DIV_DEN_W-1:0] r_ff, r_in;
   logic [DIV_DEN_W-1:0] d_ff, d_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DIV_DEN_W:0]   r_shift;
   logic [DIV_DEN_W:0]   r_diff;
   logic                 ge;

   always_comb begin
      r_shift = {r_ff, q_ff[DIV_NUM_W-1]};
      r_diff  = r_shift - {1'b0, d_ff};
      ge      = (r_shift >= {1'b0, d_ff});

      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (div_req.start) begin
         q_in    = div_req.num;
         r_in    = '0;
         d_in    = div_req.den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = {q_ff[DIV_NUM_W-2:0], ge};
         r_in   = ge ? r_diff[DIV_DEN_W-1:0] : r_shift[DIV_DEN_W-1:0];
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = q_ff;

endmodule
